// File: hw/rtl/pre_trade_risk_gate_assert.svh
// Assertion macros for the pre-trade risk gate RTL.
// Included by the modules that carry concurrent checks; relies on clk and rst in scope.
`ifndef PRE_TRADE_RISK_GATE_ASSERT_SVH
`define PRE_TRADE_RISK_GATE_ASSERT_SVH
`ifndef SYNTHESIS
`define RTG_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("rtg assertion failed");
`define RTG_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rtg assertion failed");
`else
`define RTG_ASSERT(lbl, cond)
`define RTG_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// File: hw/rtl/rtg_pkg.sv
// Shared types and constants for the pre-trade risk gate.
// No dependencies.
`timescale 1ns / 1ps
package rtg_pkg;
  localparam int SYMBOL_COUNT = 256;
  localparam int SYM_BITS = $clog2(SYMBOL_COUNT);
  localparam int TIME_BITS = 48;
  localparam int WINDOW_DEPTH = 64;
  localparam int WIN_BITS = $clog2(WINDOW_DEPTH);
  localparam int CNT_BITS = WIN_BITS + 1;
  localparam logic [TIME_BITS-1:0] WINDOW_SPAN = TIME_BITS'(60000);
  localparam logic [CNT_BITS-1:0] WIN_COUNT_MAX = CNT_BITS'(WINDOW_DEPTH);
  localparam logic FUNC_RECORD = 1'b1;

  typedef enum logic [2:0] {
    DEC_ACCEPT, DEC_DISCONNECTED, DEC_STALE, DEC_LATENCY, DEC_SIZE, DEC_RISK, DEC_COOLDOWN
  } decision_t;

  typedef enum logic [3:0] {
    RSN_OK, RSN_BUY_DOWN, RSN_SELL_DOWN, RSN_STALE, RSN_LATENCY, RSN_SIZE,
    RSN_EXPOSURE, RSN_COOLDOWN, RSN_RATE
  } reason_t;

  typedef enum logic [2:0] {
    CFG_MAX_TICK_AGE, CFG_MAX_ROUND_TRIP, CFG_MIN_QUANTITY, CFG_MAX_QUANTITY,
    CFG_EXPOSURE_CAP, CFG_COOLDOWN_TIME, CFG_TRADES_PER_MINUTE
  } cfg_index_t;

  typedef enum logic [1:0] {ST_IDLE, ST_LOOKUP, ST_SWEEP} state_t;

  typedef struct packed {
    logic [31:0] max_tick_age;
    logic [15:0] max_round_trip;
    logic [31:0] min_quantity;
    logic [31:0] max_quantity;
    logic [32:0] exposure_cap;
    logic [31:0] cooldown_time;
    logic [6:0]  trades_per_minute;
  } cfg_t;

  typedef struct packed {
    logic                 record;
    logic [SYM_BITS-1:0]  sym;
    logic [TIME_BITS-1:0] now;
    logic                 early_fail;
    decision_t            decision;
    reason_t              reason;
  } cmd_t;
endpackage

// File: hw/rtl/rtg_if.sv
// Valid/ready channel interfaces for order beats and verdict beats.
// Depends on rtg_pkg.
`timescale 1ns / 1ps
interface rtg_in_if;
  logic valid;
  logic ready;
  logic func;
  logic [rtg_pkg::SYM_BITS-1:0] symbol_index;
  logic [rtg_pkg::TIME_BITS-1:0] now_ms;
  logic buy_link_up;
  logic sell_link_up;
  logic [rtg_pkg::TIME_BITS-1:0] best_tick_ms;
  logic [15:0] round_trip_ms;
  logic [31:0] quantity;
  logic [31:0] open_exposure;
  modport source (output valid, func, symbol_index, now_ms, buy_link_up, sell_link_up,
                  best_tick_ms, round_trip_ms, quantity, open_exposure, input ready);
  modport sink (input valid, func, symbol_index, now_ms, buy_link_up, sell_link_up,
                best_tick_ms, round_trip_ms, quantity, open_exposure, output ready);
endinterface

interface rtg_out_if;
  logic valid;
  logic ready;
  logic [2:0] decision;
  logic [3:0] reason;
  modport source (output valid, decision, reason, input ready);
  modport sink (input valid, decision, reason, output ready);
endinterface

// File: hw/rtl/rtg_front.sv
// Front end: accepts order beats, runs the stateless checks, registers the command.
// Depends on rtg_pkg and rtg_if.
`timescale 1ns / 1ps
module rtg_front (
  input  logic          clk,
  input  logic          rst,
  rtg_in_if.sink        orders,
  input  rtg_pkg::cfg_t cfg,
  output rtg_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready
);
  rtg_pkg::cmd_t cls;
  logic [rtg_pkg::TIME_BITS-1:0] age;
  logic [32:0] expo;

  always_comb begin
    age  = orders.now_ms - orders.best_tick_ms;
    expo = {1'b0, orders.open_exposure} + {1'b0, orders.quantity};
    cls.record     = orders.func;
    cls.sym        = orders.symbol_index;
    cls.now        = orders.now_ms;
    cls.early_fail = 1'b1;
    cls.decision   = rtg_pkg::DEC_ACCEPT;
    cls.reason     = rtg_pkg::RSN_OK;
    if (orders.func == rtg_pkg::FUNC_RECORD) begin
      cls.early_fail = 1'b0;
    end else if (!orders.buy_link_up) begin
      cls.decision = rtg_pkg::DEC_DISCONNECTED;
      cls.reason   = rtg_pkg::RSN_BUY_DOWN;
    end else if (!orders.sell_link_up) begin
      cls.decision = rtg_pkg::DEC_DISCONNECTED;
      cls.reason   = rtg_pkg::RSN_SELL_DOWN;
    end else if (orders.now_ms > orders.best_tick_ms &&
                 age > {16'b0, cfg.max_tick_age}) begin
      cls.decision = rtg_pkg::DEC_STALE;
      cls.reason   = rtg_pkg::RSN_STALE;
    end else if (orders.round_trip_ms > cfg.max_round_trip) begin
      cls.decision = rtg_pkg::DEC_LATENCY;
      cls.reason   = rtg_pkg::RSN_LATENCY;
    end else if (orders.quantity < cfg.min_quantity ||
                 orders.quantity > cfg.max_quantity) begin
      cls.decision = rtg_pkg::DEC_SIZE;
      cls.reason   = rtg_pkg::RSN_SIZE;
    end else if (expo > cfg.exposure_cap) begin
      cls.decision = rtg_pkg::DEC_RISK;
      cls.reason   = rtg_pkg::RSN_EXPOSURE;
    end else begin
      cls.early_fail = 1'b0;
    end
  end

  assign orders.ready = !cmd_valid || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (orders.valid && orders.ready) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (orders.valid && orders.ready) begin
      cmd <= cls;
    end
  end
endmodule

// File: hw/rtl/rtg_queue.sv
// Two-entry command queue between front and back ends.
// Depends on rtg_pkg.
`timescale 1ns / 1ps
module rtg_queue (
  input  logic          clk,
  input  logic          rst,
  input  rtg_pkg::cmd_t in_cmd,
  input  logic          in_valid,
  output logic          in_ready,
  output rtg_pkg::cmd_t out_cmd,
  output logic          out_valid,
  input  logic          out_ready
);
  rtg_pkg::cmd_t slots [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] fill;
  logic push;
  logic pop;

  assign in_ready  = fill != 2'd2;
  assign out_valid = fill != 2'd0;
  assign out_cmd   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_cmd;
  end
endmodule

// File: hw/rtl/rtg_back.sv
// Back end: last-trade table, trade-time ring with pruning sweep, verdict register.
// Depends on rtg_pkg, rtg_if and the assertion header.
`timescale 1ns / 1ps
`include "pre_trade_risk_gate_assert.svh"
module rtg_back (
  input  logic          clk,
  input  logic          rst,
  input  rtg_pkg::cfg_t cfg,
  input  rtg_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  rtg_out_if.source     verdicts
);
  localparam int TB = rtg_pkg::TIME_BITS;
  localparam int WB = rtg_pkg::WIN_BITS;
  localparam int CB = rtg_pkg::CNT_BITS;

  rtg_pkg::state_t state, state_next;
  logic [TB-1:0] tbl [rtg_pkg::SYMBOL_COUNT];
  logic [rtg_pkg::SYMBOL_COUNT-1:0] tbl_valid;
  logic [TB-1:0] ring [rtg_pkg::WINDOW_DEPTH];

  logic [WB-1:0] win_head;
  logic [CB-1:0] win_count;
  logic [CB-1:0] rd_idx;
  logic [CB-1:0] kept;
  logic rd_pend;
  logic [TB-1:0] ring_q;
  logic [TB-1:0] tbl_q;
  logic tbl_q_valid;
  logic [TB-1:0] cur_now;
  logic [TB-1:0] cutoff;

  logic pop, rec, full, issue, keep, done, cool_fail, early_clock;
  logic ring_we;
  logic [WB-1:0] ring_waddr, rd_addr;
  logic out_load;
  rtg_pkg::decision_t out_dec;
  rtg_pkg::reason_t out_rsn;

  assign pop         = cmd_valid && cmd_ready;
  assign rec         = pop && cmd.record;
  assign full        = win_count == rtg_pkg::WIN_COUNT_MAX;
  assign issue       = rd_idx < win_count;
  assign keep        = rd_pend && ring_q >= cutoff;
  assign done        = !issue && !rd_pend;
  assign rd_addr     = win_head + rd_idx[WB-1:0];
  assign early_clock = cur_now < rtg_pkg::WINDOW_SPAN;
  assign cool_fail   = tbl_q_valid &&
                       (tbl_q > cur_now || (cur_now - tbl_q) < {16'b0, cfg.cooldown_time});

  always_comb begin
    state_next = state;
    case (state)
      rtg_pkg::ST_IDLE: begin
        if (pop && !cmd.record && !cmd.early_fail) state_next = rtg_pkg::ST_LOOKUP;
      end
      rtg_pkg::ST_LOOKUP: begin
        if (!cool_fail && !early_clock) state_next = rtg_pkg::ST_SWEEP;
        else state_next = rtg_pkg::ST_IDLE;
      end
      rtg_pkg::ST_SWEEP: begin
        if (done) state_next = rtg_pkg::ST_IDLE;
      end
      default: state_next = rtg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready  = 1'b0;
    out_load   = 1'b0;
    out_dec    = rtg_pkg::DEC_ACCEPT;
    out_rsn    = rtg_pkg::RSN_OK;
    ring_we    = 1'b0;
    ring_waddr = win_head + kept[WB-1:0];
    case (state)
      rtg_pkg::ST_IDLE: begin
        cmd_ready = !verdicts.valid;
        if (rec) begin
          ring_we    = 1'b1;
          ring_waddr = full ? win_head : win_head + win_count[WB-1:0];
        end
        if (pop && !cmd.record && cmd.early_fail) begin
          out_load = 1'b1;
          out_dec  = cmd.decision;
          out_rsn  = cmd.reason;
        end
      end
      rtg_pkg::ST_LOOKUP: begin
        if (cool_fail) begin
          out_load = 1'b1;
          out_dec  = rtg_pkg::DEC_COOLDOWN;
          out_rsn  = rtg_pkg::RSN_COOLDOWN;
        end else if (early_clock) begin
          out_load = 1'b1;
          if (win_count >= cfg.trades_per_minute) begin
            out_dec = rtg_pkg::DEC_RISK;
            out_rsn = rtg_pkg::RSN_RATE;
          end
        end
      end
      rtg_pkg::ST_SWEEP: begin
        ring_we = keep;
        if (done) begin
          out_load = 1'b1;
          if (kept >= cfg.trades_per_minute) begin
            out_dec = rtg_pkg::DEC_RISK;
            out_rsn = rtg_pkg::RSN_RATE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= rtg_pkg::ST_IDLE;
      tbl_valid      <= '0;
      win_head       <= '0;
      win_count      <= '0;
      rd_pend        <= 1'b0;
      verdicts.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) verdicts.valid <= 1'b1;
      else if (verdicts.ready) verdicts.valid <= 1'b0;
      if (rec) begin
        tbl_valid[cmd.sym] <= 1'b1;
        if (full) win_head <= win_head + 1'b1;
        else win_count <= win_count + 1'b1;
      end
      rd_pend <= (state == rtg_pkg::ST_SWEEP) && issue;
      if (state == rtg_pkg::ST_SWEEP && done) win_count <= kept;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      verdicts.decision <= out_dec;
      verdicts.reason   <= out_rsn;
    end
    if (pop) begin
      cur_now     <= cmd.now;
      tbl_q_valid <= tbl_valid[cmd.sym];
    end
    if (state == rtg_pkg::ST_LOOKUP) begin
      cutoff <= cur_now - rtg_pkg::WINDOW_SPAN;
      rd_idx <= '0;
      kept   <= '0;
    end else if (state == rtg_pkg::ST_SWEEP) begin
      if (issue) rd_idx <= rd_idx + 1'b1;
      if (keep) kept <= kept + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rec) tbl[cmd.sym] <= cmd.now;
    tbl_q <= tbl[cmd.sym];
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring[ring_waddr] <= (state == rtg_pkg::ST_SWEEP) ? ring_q : cmd.now;
    ring_q <= ring[rd_addr];
  end

  `RTG_ASSERT(a_count_bound, win_count <= rtg_pkg::WIN_COUNT_MAX)
  `RTG_ASSERT(a_kept_le_read, state != rtg_pkg::ST_SWEEP || kept <= rd_idx)
  `RTG_ASSERT(a_pend_in_sweep, !rd_pend || state == rtg_pkg::ST_SWEEP)
  `RTG_ASSERT_NEXT(a_record_fills, rec, win_count != '0)
endmodule

// File: hw/rtl/pre_trade_risk_gate.sv
// Top level of the pre-trade risk gate: configuration registers, front, queue, back.
// Depends on rtg_pkg, rtg_if, rtg_front, rtg_queue and rtg_back.
//
//   channel    dir   beat
//   orders     in    func, symbol, times, link flags, size, exposure
//   verdicts   out   decision, reason (one per check, none per record)
//   cfg_*      in    register write, index 0..6, no read-back
//
// A record is taken while idle. A check failing a stateless test gets its verdict
// from idle, one failing cooldown or with now below 60000 ms from the lookup state,
// and any other from the pruning sweep over the 64-entry ring after the lookup.
// The front register feeds the two-entry queue, which absorbs back-end stalls.
// The back end pops a command only while idle and the verdict register is empty.
// Synchronous reset; the last-trade valid bits clear at once, no clearing pass.
`timescale 1ns / 1ps
module pre_trade_risk_gate (
  input  logic        clk,
  input  logic        rst,
  rtg_in_if.sink      orders,
  rtg_out_if.source   verdicts,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [32:0] cfg_data
);
  rtg_pkg::cfg_t cfg;
  rtg_pkg::cmd_t f_cmd, q_cmd;
  logic f_valid, f_ready, q_valid, q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_tick_age      <= 32'd1000;
      cfg.max_round_trip    <= 16'd50;
      cfg.min_quantity      <= 32'd1;
      cfg.max_quantity      <= 32'd1000;
      cfg.exposure_cap      <= 33'd10000;
      cfg.cooldown_time     <= 32'd1000;
      cfg.trades_per_minute <= 7'd10;
    end else if (cfg_we) begin
      case (rtg_pkg::cfg_index_t'(cfg_index))
        rtg_pkg::CFG_MAX_TICK_AGE:      cfg.max_tick_age      <= cfg_data[31:0];
        rtg_pkg::CFG_MAX_ROUND_TRIP:    cfg.max_round_trip    <= cfg_data[15:0];
        rtg_pkg::CFG_MIN_QUANTITY:      cfg.min_quantity      <= cfg_data[31:0];
        rtg_pkg::CFG_MAX_QUANTITY:      cfg.max_quantity      <= cfg_data[31:0];
        rtg_pkg::CFG_EXPOSURE_CAP:      cfg.exposure_cap      <= cfg_data;
        rtg_pkg::CFG_COOLDOWN_TIME:     cfg.cooldown_time     <= cfg_data[31:0];
        rtg_pkg::CFG_TRADES_PER_MINUTE: cfg.trades_per_minute <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  rtg_front u_front (
    .clk(clk), .rst(rst), .orders(orders), .cfg(cfg),
    .cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready)
  );

  rtg_queue u_queue (
    .clk(clk), .rst(rst),
    .in_cmd(f_cmd), .in_valid(f_valid), .in_ready(f_ready),
    .out_cmd(q_cmd), .out_valid(q_valid), .out_ready(q_ready)
  );

  rtg_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .cmd(q_cmd), .cmd_valid(q_valid), .cmd_ready(q_ready), .verdicts(verdicts)
  );
endmodule
